@@ rtl/scancode_to_ascii_translator_defines.svh @@
// Assertion macros for the scan code translator checker.
// Depends on nothing; expects clk and rst in the scope of each use.
`ifndef SCANCODE_TO_ASCII_TRANSLATOR_DEFINES_SVH
`define SCANCODE_TO_ASCII_TRANSLATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define SAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scan code translator check failed");

// next-cycle implication, off during reset
`define SAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scan code translator check failed");

`endif

@@ rtl/sat_pkg.sv @@
// Shared types and constants for the scan code translator.
// Depends on nothing.
`default_nettype none

package sat_pkg;

  localparam logic [6:0] KEY_LSHIFT = 7'h2a;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CAPS   = 7'h3a;
  localparam logic [6:0] KEY_NUM    = 7'h45;
  localparam logic [6:0] KEY_SCROLL = 7'h46;

  localparam logic [6:0] CASE_BIT      = 7'h20;
  localparam logic [6:0] CHAR_UPPER_A  = 7'h41;
  localparam logic [6:0] CHAR_UPPER_Z  = 7'h5a;
  localparam logic [6:0] CHAR_LOWER_A  = 7'h61;
  localparam logic [6:0] CHAR_LOWER_Z  = 7'h7a;

  localparam int LED_CAPS   = 2;
  localparam int LED_NUM    = 1;
  localparam int LED_SCROLL = 0;

  typedef logic [7:0] scan_t;
  typedef logic [2:0] leds_t;

  typedef struct packed {
    logic       is_make;
    logic [6:0] char_code;
    logic       is_letter;
    logic [6:0] key_code;
    logic       leds_changed;
    logic [2:0] led_state;
  } result_t;

  typedef struct packed {
    logic  shift_any;
    logic  caps;
    leds_t leds;
    logic  toggled;
  } key_upd_t;

endpackage

`default_nettype wire

@@ rtl/sat_chan_if.sv @@
// Valid/ready channel carrying one payload per beat.
// Depends on nothing; payload type set per instance.
`default_nettype none

interface sat_chan_if #(parameter type data_t = logic [7:0]);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/scancode_to_ascii_translator.sv @@
// Top level of the set-1 scan code to ASCII translator.
// Depends on sat_pkg, sat_chan_if, sat_keystate and sat_xlate.
//
//   channel  | dir | payload                  | beat
//   scan     | in  | scan_code, 8 bits        | one scan code byte
//   result   | out | sat_pkg::result_t        | one translated key event
//   cfg      | in  | boot_leds, 3 bits        | load lock LEDs
//
// Scan codes pass the input then the result register; one per cycle sustained while result is ready.
// The input register and the result register each hold one code, so a stalled
// result still lets the next code in. Reset clears shift and LED state and empties
// both registers. cfg is always ready and loads the lock LEDs directly.
`default_nettype none

module scancode_to_ascii_translator (
  input  logic       clk,
  input  logic       rst,
  sat_chan_if.sink   cfg,
  sat_chan_if.sink   scan,
  sat_chan_if.source result
);
  import sat_pkg::*;

  logic     in_valid;
  scan_t    in_code;
  logic     out_valid;
  result_t  out_data;
  result_t  out_data_next;
  logic     advance;
  key_upd_t upd;
  logic [6:0] char_code;
  logic       is_letter;

  assign advance    = in_valid && (!out_valid || result.ready);
  assign scan.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (scan.ready) begin
      in_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      in_code <= scan.data[7:0];
    end
  end

  sat_keystate u_keystate (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .code      (in_code),
    .load      (cfg.valid),
    .load_leds (cfg.data[2:0]),
    .upd       (upd)
  );

  sat_xlate u_xlate (
    .key       (in_code[6:0]),
    .shift_any (upd.shift_any),
    .caps      (upd.caps),
    .char_code (char_code),
    .is_letter (is_letter)
  );

  always_comb begin
    out_data_next.is_make      = ~in_code[7];
    out_data_next.char_code    = char_code;
    out_data_next.is_letter    = is_letter;
    out_data_next.key_code     = in_code[6:0];
    out_data_next.leds_changed = upd.toggled;
    out_data_next.led_state    = upd.leds;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

`default_nettype wire

@@ rtl/sat_keystate.sv @@
// Shift-held and lock LED state with its per-code update.
// Depends on sat_pkg.
`default_nettype none

module sat_keystate (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  sat_pkg::scan_t   code,
  input  logic             load,
  input  sat_pkg::leds_t   load_leds,
  output sat_pkg::key_upd_t upd
);
  import sat_pkg::*;

  logic [1:0] shift_held;
  logic [1:0] shift_held_next;
  leds_t      lock_leds;
  leds_t      lock_leds_next;
  logic       make;
  logic [6:0] key;
  logic       toggled;

  assign make = ~code[7];
  assign key  = code[6:0];

  always_comb begin
    shift_held_next = shift_held;
    lock_leds_next  = lock_leds;
    toggled         = 1'b0;
    if (key == KEY_LSHIFT) begin
      shift_held_next[0] = make;
    end else if (key == KEY_RSHIFT) begin
      shift_held_next[1] = make;
    end else if (make && key == KEY_CAPS) begin
      lock_leds_next[LED_CAPS] = ~lock_leds[LED_CAPS];
      toggled = 1'b1;
    end else if (make && key == KEY_NUM) begin
      lock_leds_next[LED_NUM] = ~lock_leds[LED_NUM];
      toggled = 1'b1;
    end else if (make && key == KEY_SCROLL) begin
      lock_leds_next[LED_SCROLL] = ~lock_leds[LED_SCROLL];
      toggled = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= '0;
      lock_leds  <= '0;
    end else if (load) begin
      lock_leds <= load_leds;
    end else if (step) begin
      shift_held <= shift_held_next;
      lock_leds  <= lock_leds_next;
    end
  end

  assign upd.shift_any = |shift_held_next;
  assign upd.caps      = lock_leds_next[LED_CAPS];
  assign upd.leds      = lock_leds_next;
  assign upd.toggled   = toggled;

endmodule

`default_nettype wire

@@ rtl/sat_xlate.sv @@
// Key number to character lookup over the plain and shifted tables.
// Depends on sat_pkg.
`default_nettype none

module sat_xlate (
  input  logic [6:0] key,
  input  logic       shift_any,
  input  logic       caps,
  output logic [6:0] char_code,
  output logic       is_letter
);
  import sat_pkg::*;

  function automatic logic [6:0] key_char(input logic [6:0] k, input logic sh);
    logic [6:0] c;
    begin
      case (k)
        7'h02: c = sh ? 7'h21 : 7'h31;
        7'h03: c = sh ? 7'h22 : 7'h32;
        7'h04: c = sh ? 7'h23 : 7'h33;
        7'h05: c = sh ? 7'h24 : 7'h34;
        7'h06: c = sh ? 7'h25 : 7'h35;
        7'h07: c = sh ? 7'h26 : 7'h36;
        7'h08: c = sh ? 7'h27 : 7'h37;
        7'h09: c = sh ? 7'h28 : 7'h38;
        7'h0a: c = sh ? 7'h29 : 7'h39;
        7'h0b: c = sh ? 7'h7e : 7'h30;
        7'h0c: c = sh ? 7'h3d : 7'h2d;
        7'h0d: c = sh ? 7'h7e : 7'h5e;
        7'h10: c = 7'h51;
        7'h11: c = 7'h57;
        7'h12: c = 7'h45;
        7'h13: c = 7'h52;
        7'h14: c = 7'h54;
        7'h15: c = 7'h59;
        7'h16: c = 7'h55;
        7'h17: c = 7'h49;
        7'h18: c = 7'h4f;
        7'h19: c = 7'h50;
        7'h1a: c = sh ? 7'h60 : 7'h40;
        7'h1b: c = sh ? 7'h7b : 7'h5b;
        7'h1e: c = 7'h41;
        7'h1f: c = 7'h53;
        7'h20: c = 7'h44;
        7'h21: c = 7'h46;
        7'h22: c = 7'h47;
        7'h23: c = 7'h48;
        7'h24: c = 7'h4a;
        7'h25: c = 7'h4b;
        7'h26: c = 7'h4c;
        7'h27: c = sh ? 7'h2b : 7'h3b;
        7'h28: c = sh ? 7'h2a : 7'h3a;
        7'h2b: c = sh ? 7'h7d : 7'h5d;
        7'h2c: c = 7'h5a;
        7'h2d: c = 7'h58;
        7'h2e: c = 7'h43;
        7'h2f: c = 7'h56;
        7'h30: c = 7'h42;
        7'h31: c = 7'h4e;
        7'h32: c = 7'h4d;
        7'h33: c = sh ? 7'h3c : 7'h2c;
        7'h34: c = sh ? 7'h3e : 7'h2e;
        7'h35: c = sh ? 7'h3f : 7'h2f;
        7'h37: c = 7'h2a;
        7'h39: c = 7'h20;
        7'h47: c = 7'h37;
        7'h48: c = 7'h38;
        7'h49: c = 7'h39;
        7'h4a: c = 7'h2d;
        7'h4b: c = 7'h34;
        7'h4c: c = 7'h35;
        7'h4d: c = 7'h36;
        7'h4e: c = 7'h2b;
        7'h4f: c = 7'h31;
        7'h50: c = 7'h32;
        7'h51: c = 7'h33;
        7'h52: c = 7'h30;
        7'h53: c = 7'h2e;
        7'h73: c = sh ? 7'h5f : 7'h00;
        7'h7d: c = sh ? 7'h7c : 7'h00;
        default: c = 7'h00;
      endcase
      return c;
    end
  endfunction

  logic [6:0] rom_char;

  assign rom_char  = key_char(key, shift_any);
  assign is_letter = (rom_char >= CHAR_UPPER_A) && (rom_char <= CHAR_UPPER_Z);
  assign char_code = (is_letter && (caps == shift_any)) ? (rom_char | CASE_BIT) : rom_char;

endmodule

`default_nettype wire

@@ rtl/sat_checker.sv @@
// Port-level checks on the translator's result channel, bound to the top level.
// Depends on sat_pkg and scancode_to_ascii_translator_defines.svh.
`default_nettype none

`include "scancode_to_ascii_translator_defines.svh"

module sat_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input sat_pkg::result_t result_data
);
  import sat_pkg::*;

  `SAT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data))
  `SAT_ASSERT_NOW(a_toggle_on_make, result_valid && result_data.leds_changed, result_data.is_make)
  `SAT_ASSERT_NOW(a_toggle_lock_key, result_valid && result_data.leds_changed, (result_data.key_code == KEY_CAPS) || (result_data.key_code == KEY_NUM) || (result_data.key_code == KEY_SCROLL))
  `SAT_ASSERT_NOW(a_letter_range, result_valid && result_data.is_letter, ((result_data.char_code >= CHAR_UPPER_A) && (result_data.char_code <= CHAR_UPPER_Z)) || ((result_data.char_code >= CHAR_LOWER_A) && (result_data.char_code <= CHAR_LOWER_Z)))

endmodule

bind scancode_to_ascii_translator sat_checker u_sat_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);

`default_nettype wire
